FILE: hdl/slf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slf_pkg: shared constants and types of the small loop filter
// Window sizes and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package slf_pkg;

    localparam int MAX_LOOP  = 10;
    localparam int WIN_DEPTH = MAX_LOOP + 1;
    localparam int CW        = 32;
    localparam int LPW       = 4;
    localparam int PTRW      = $clog2(WIN_DEPTH);
    localparam int RING      = 1 << PTRW;
    localparam int CNTW      = $clog2(WIN_DEPTH + 1);

    localparam logic CFG_LOOP_POINTS = 1'b0;
    localparam logic CFG_LOOP_EXTENT = 1'b1;

    typedef struct packed {
        logic append;
        logic rd_head;
        logic load_old;
        logic emit;
        logic update;
        logic check;
        logic drop;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic decide;
        logic emit_ready;
        logic scan_more;
        logic hit;
        logic fin_ready;
    } t_sts;

endpackage

FILE: hdl/slf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slf_ctrl: sequencer of the small loop filter
// Steps through append, decide (oldest read, emit, loop scan, drop) and the
// end-of-step flush, at most one command group per cycle; the emit and the flush wait while the output is stalled.
// ----------------------------------------------------------------------------
module slf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  slf_pkg::t_sts  i_sts,
    output slf_pkg::t_cmd  o_cmd,
    output logic           o_idle
);
    import slf_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_RD0   = 4'd2;
    localparam logic [3:0] S_OLD   = 4'd3;
    localparam logic [3:0] S_EMIT  = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_UPD   = 4'd6;
    localparam logic [3:0] S_CHK   = 4'd7;
    localparam logic [3:0] S_DROP  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.append = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_sts.decide ? S_RD0 : S_FIN;
            end
            S_RD0: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_OLD;
            end
            S_OLD: begin
                o_cmd.load_old = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.emit_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // The read of the next window entry is issued here.
                n_state = i_sts.scan_more ? S_UPD : S_DROP;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHK;
            end
            S_CHK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.hit ? S_DROP : S_SCAN;
            end
            S_DROP: begin
                o_cmd.drop = 1'b1;
                n_state    = S_CHECK;
            end
            S_FIN: begin
                if (i_sts.fin_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

FILE: hdl/slf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slf_dp: datapath of the small loop filter
// Window ring memory, loop bounding box, last emitted point, held result
// and output word register, plus the configuration registers.
// ----------------------------------------------------------------------------
module slf_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  slf_pkg::t_cmd             i_cmd,
    output slf_pkg::t_sts             o_sts,
    input  logic [2*slf_pkg::CW-1:0]  i_pt,
    input  logic                      i_eol,
    input  logic                      i_cfg_wr_en,
    input  logic                      i_cfg_idx,
    input  logic [slf_pkg::CW-1:0]    i_cfg_wdata,
    output logic [2*slf_pkg::CW-1:0]  o_data,
    output logic                      o_has,
    output logic                      o_last,
    output logic                      o_valid,
    input  logic                      i_ready
);
    import slf_pkg::*;

    logic [LPW-1:0]     r_lp;
    logic [CW-1:0]      r_ext;
    logic [2*CW-1:0]    r_mem [RING];
    logic [2*CW-1:0]    r_rd;
    logic [PTRW-1:0]    r_head;
    logic [CNTW-1:0]    r_count;
    logic [CNTW-1:0]    r_j;
    logic [CNTW-1:0]    r_skip;
    logic               r_eol;
    logic [2*CW-1:0]    r_old;
    logic signed [CW-1:0] r_minx, r_maxx, r_miny, r_maxy;
    logic               r_eq;
    logic               r_emit;
    logic [2*CW-1:0]    r_prev;
    logic               r_prev_v;
    logic [2*CW-1:0]    r_pend;
    logic               r_pend_v;
    logic [2*CW-1:0]    r_out;
    logic               r_out_has, r_out_last, r_out_v;

    logic [LPW-1:0]     lp_sat;
    logic [PTRW-1:0]    rd_addr;
    logic signed [CW-1:0] px, py;
    logic [CW:0]        w, h;
    logic               fit;
    logic               out_free;
    logic               fin_push;

    assign lp_sat   = (r_lp > LPW'(MAX_LOOP)) ? LPW'(MAX_LOOP) : r_lp;
    assign rd_addr  = i_cmd.rd_head ? r_head : r_head + PTRW'(r_j);
    assign px       = r_rd[CW-1:0];
    assign py       = r_rd[2*CW-1:CW];
    assign w        = {r_maxx[CW-1], r_maxx} - {r_minx[CW-1], r_minx};
    assign h        = {r_maxy[CW-1], r_maxy} - {r_miny[CW-1], r_miny};
    assign fit      = (w < {1'b0, r_ext}) && (h < {1'b0, r_ext});
    assign out_free = !r_out_v || i_ready;
    assign fin_push = r_pend_v || r_eol;

    assign o_sts.decide     = (r_count != '0) &&
                              (r_eol || (r_count > CNTW'(lp_sat)));
    assign o_sts.emit_ready = !r_emit || !r_pend_v || out_free;
    assign o_sts.scan_more  = (r_j <= CNTW'(lp_sat)) && (r_j < r_count);
    assign o_sts.hit        = r_eq && fit;
    assign o_sts.fin_ready  = !fin_push || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp  <= LPW'(MAX_LOOP);
            r_ext <= CW'(655360);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_LOOP_POINTS: r_lp  <= i_cfg_wdata[LPW-1:0];
                CFG_LOOP_EXTENT: r_ext <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Window ring: written at the tail on append while not full, one read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && (r_count < CNTW'(WIN_DEPTH))) begin
            r_mem[r_head + PTRW'(r_count)] <= i_pt;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_count    <= '0;
            r_prev_v   <= 1'b0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_eol      <= 1'b0;
            r_emit     <= 1'b0;
        end else begin
            if ((i_cmd.emit && r_emit && r_pend_v) || (i_cmd.finish && fin_push)) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
            if (i_cmd.append) begin
                r_eol <= i_eol;
                if (r_count < CNTW'(WIN_DEPTH)) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.load_old) begin
                r_emit <= !(r_prev_v && (r_prev == r_rd));
            end
            if (i_cmd.emit && r_emit) begin
                r_pend_v <= 1'b1;
                r_prev_v <= 1'b1;
            end
            if (i_cmd.drop) begin
                r_head  <= r_head + PTRW'(r_skip) + 1'b1;
                r_count <= r_count - r_skip - 1'b1;
            end
            if (i_cmd.finish) begin
                if (fin_push) begin
                    r_pend_v <= 1'b0;
                end
                if (r_eol) begin
                    r_count  <= '0;
                    r_prev_v <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_old) begin
            r_old  <= r_rd;
            r_minx <= px;
            r_maxx <= px;
            r_miny <= py;
            r_maxy <= py;
            r_j    <= CNTW'(1);
            r_skip <= '0;
        end
        if (i_cmd.emit && r_emit) begin
            if (r_pend_v) begin
                r_out      <= r_pend;
                r_out_has  <= 1'b1;
                r_out_last <= 1'b0;
            end
            r_pend <= r_old;
            r_prev <= r_old;
        end
        if (i_cmd.update) begin
            if (px < r_minx) r_minx <= px;
            if (px > r_maxx) r_maxx <= px;
            if (py < r_miny) r_miny <= py;
            if (py > r_maxy) r_maxy <= py;
            r_eq <= (r_rd == r_old);
        end
        if (i_cmd.check) begin
            if (r_eq && fit) begin
                r_skip <= r_j;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
        if (i_cmd.finish && fin_push) begin
            // A step that emitted nothing closes with a bare end marker at the end of a line.
            r_out      <= r_pend_v ? r_pend : '0;
            r_out_has  <= r_pend_v;
            r_out_last <= r_eol;
        end
    end

    assign o_data  = r_out;
    assign o_has   = r_out_has;
    assign o_last  = r_out_last;
    assign o_valid = r_out_v;

endmodule

FILE: hdl/small_loop_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_loop_filter_top: polyline small-loop and duplicate remover
// Channel   Dir  Handshake        Contents
// s_axis    in   tvalid/tready    tdata: pt_x, pt_y; tlast: end_of_line
// m_axis    out  tvalid/tready    tdata: out_x, out_y; tuser: has_point;
//                                 tlast: run_last
// cfg       in   wr_en            idx 0 loop_points, 1 loop_extent
//
// One word is taken at a time. Each step appends the word and, per decided
// point, reads the oldest entry, emits it unless it repeats the last emitted
// point, scans up to ten window entries (one memory read, box update, extent
// compare each) and drops the oldest entry or the cut loop; then it flushes.
// The last result of a step is held until the step ends. Reset is
// synchronous; a stalled output holds the sequencer in its emit or flush.
// ----------------------------------------------------------------------------
module small_loop_filter_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [2*slf_pkg::CW-1:0]   i_s_axis_tdata,  // pt_x, pt_y
    input  logic                       i_s_axis_tlast,  // end_of_line
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [2*slf_pkg::CW-1:0]   o_m_axis_tdata,  // out_x, out_y
    output logic                       o_m_axis_tuser,  // has_point
    output logic                       o_m_axis_tlast,  // run_last
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_idx,
    input  logic [slf_pkg::CW-1:0]     i_cfg_wdata
);
    import slf_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic idle;
    logic accept;

    assign accept          = i_s_axis_tvalid && idle;
    assign o_s_axis_tready = idle;

    slf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_idle   (idle)
    );

    slf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_pt        (i_s_axis_tdata),
        .i_eol       (i_s_axis_tlast),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_data      (o_m_axis_tdata),
        .o_has       (o_m_axis_tuser),
        .o_last      (o_m_axis_tlast),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready)
    );

endmodule

FILE: hdl/slf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slf_checker: port-level checks of the small loop filter
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module slf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output word changed while stalled");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second word taken during a step");

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("bare end marker without run_last");

endmodule

bind small_loop_filter_top slf_checker u_slf_checker (.*);
